// ----- rtl/assert_macros.svh -----
// Assertion macros for the self-checking RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CRDE_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CRDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crde_pkg.sv -----
// Types, constants and codes of the raster draw engine
`default_nettype none
package crde_pkg;

    localparam int MAX_CANVAS_WIDTH  = 256;
    localparam int MAX_CANVAS_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 16;
    localparam int COLOR_W   = 32;
    localparam int COUNT_W   = 18;
    localparam int OP_W      = 3;
    localparam int GEO_W     = 20;

    localparam int XC_W   = $clog2(MAX_CANVAS_WIDTH + 1);
    localparam int YC_W   = $clog2(MAX_CANVAS_HEIGHT + 1);
    localparam int DEPTH  = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]     CFG_RESET = CFG_W'(256);
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL   = 3'd0,
        OP_FILL    = 3'd1,
        OP_OUTLINE = 3'd2,
        OP_LINE    = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        JOB_NOP,
        JOB_FILL,
        JOB_OUTLINE,
        JOB_LINE,
        JOB_READ
    } job_kind_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SETUP,
        B_FILL,
        B_LSETUP,
        B_LINE,
        B_READ,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [COORD_W-1:0] x_a;
        logic signed [COORD_W-1:0] y_a;
        logic signed [COORD_W-1:0] x_b;
        logic signed [COORD_W-1:0] y_b;
        logic [SIZE_W-1:0]         rect_width;
        logic [SIZE_W-1:0]         rect_height;
        logic [SIZE_W-1:0]         thickness;
        logic [COLOR_W-1:0]        color;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic [COUNT_W-1:0] pixels_written;
    } res_t;

    typedef struct packed {
        job_kind_t                 kind;
        logic signed [COORD_W-1:0] x_a;
        logic signed [COORD_W-1:0] y_a;
        logic signed [COORD_W-1:0] x_b;
        logic signed [COORD_W-1:0] y_b;
        logic [SIZE_W-1:0]         rect_width;
        logic [SIZE_W-1:0]         rect_height;
        logic [SIZE_W-1:0]         thickness;
        logic [COLOR_W-1:0]        color;
    } job_t;

    typedef struct packed {
        logic [CFG_W-1:0] aw;
        logic [CFG_W-1:0] ah;
    } dims_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_status_t;

endpackage
`default_nettype wire

// ----- rtl/canvas_raster_draw_engine_core.sv -----
// Top level of the raster draw engine: front end, job queue, back end
// A fill writes its pixels in turn; a line visits every point, inside the canvas or not;
// an outline runs as four fills, each with its own setup step.
// Throughput: one canvas write per cycle; commands run one at a time in the back end.
// Reset: rst_n clears control at once, then all MAX_CANVAS_WIDTH*MAX_CANVAS_HEIGHT canvas
// words are swept to zero while in_stall is held high.
`default_nettype none
`include "assert_macros.svh"
module canvas_raster_draw_engine_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [crde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crde_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire crde_pkg::cmd_t                 in_word,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output crde_pkg::res_t                      out_word
);
    import crde_pkg::*;

    logic         q_push, q_pop, q_full, q_empty;
    job_t         q_job, q_head;
    dims_t        dims;
    back_status_t status;

    crde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .in_stall  (in_stall),
        .q_full    (q_full),
        .status    (status),
        .q_push    (q_push),
        .q_job     (q_job),
        .dims      (dims)
    );

    crde_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_job),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    crde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    `CRDE_ASSERT(a_no_push_full, clk, rst_n, q_push, !q_full, "push into full queue")
    `CRDE_ASSERT(a_clear_quiet, clk, rst_n, status.clearing, !out_valid && !q_push, "busy in clear")
    `CRDE_ASSERT(a_queue_sane, clk, rst_n, q_full, !q_empty, "queue full and empty")
    `CRDE_ASSERT_NEXT(a_pop_busy, clk, rst_n, q_pop, !status.idle && !status.clearing, "idle after pop")

endmodule
`default_nettype wire

// ----- rtl/crde_front.sv -----
// Front end: canvas registers, command accept and decode into jobs
`default_nettype none
module crde_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [crde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crde_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    input  wire crde_pkg::cmd_t                in_word,
    output logic                               in_stall,
    input  wire logic                          q_full,
    input  wire crde_pkg::back_status_t        status,
    output logic                               q_push,
    output crde_pkg::job_t                     q_job,
    output crde_pkg::dims_t                    dims
);
    import crde_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  width_next  = cfg_data;
                REG_CANVAS_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_RESET;
            height_reg <= CFG_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // clamp to the built canvas
    always_comb
    begin
        dims.aw = width_reg;
        dims.ah = height_reg;
        if (int'(width_reg) > MAX_CANVAS_WIDTH)
            dims.aw = CFG_W'(MAX_CANVAS_WIDTH);
        if (int'(height_reg) > MAX_CANVAS_HEIGHT)
            dims.ah = CFG_W'(MAX_CANVAS_HEIGHT);
    end

    assign in_stall = q_full || status.clearing;
    assign q_push   = in_valid && !in_stall;

    always_comb
    begin
        q_job.kind        = JOB_NOP;
        q_job.x_a         = in_word.x_a;
        q_job.y_a         = in_word.y_a;
        q_job.x_b         = in_word.x_b;
        q_job.y_b         = in_word.y_b;
        q_job.rect_width  = in_word.rect_width;
        q_job.rect_height = in_word.rect_height;
        q_job.thickness   = in_word.thickness;
        q_job.color       = in_word.color;
        case (in_word.operation)
            OP_PIXEL:
            begin
                q_job.kind = JOB_LINE;
                q_job.x_b  = in_word.x_a;
                q_job.y_b  = in_word.y_a;
            end
            OP_FILL:    q_job.kind = JOB_FILL;
            OP_OUTLINE: q_job.kind = JOB_OUTLINE;
            OP_LINE:    q_job.kind = JOB_LINE;
            OP_CLEAR:
            begin
                q_job.kind        = JOB_FILL;
                q_job.x_a         = '0;
                q_job.y_a         = '0;
                q_job.rect_width  = SIZE_W'(dims.aw);
                q_job.rect_height = SIZE_W'(dims.ah);
            end
            OP_READ:    q_job.kind = JOB_READ;
            default:    q_job.kind = JOB_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/crde_queue.sv -----
// Short job queue between front and back end
`default_nettype none
module crde_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire crde_pkg::job_t wdata,
    input  wire logic           pop,
    output crde_pkg::job_t      head,
    output logic                full,
    output logic                empty
);
    import crde_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

endmodule
`default_nettype wire

// ----- rtl/crde_back.sv -----
// Back end: canvas memory, span fill and line walker, result register
`default_nettype none
module crde_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire crde_pkg::dims_t        dims,
    input  wire logic                   q_empty,
    input  wire crde_pkg::job_t         q_head,
    output logic                        q_pop,
    output crde_pkg::back_status_t      status,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output crde_pkg::res_t              out_word
);
    import crde_pkg::*;

    logic [COLOR_W-1:0] canvas_mem [DEPTH];
    logic [COLOR_W-1:0] rd_q;

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [1:0]  fidx_reg, fidx_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [XC_W-1:0] cx_reg, cx_next, x1_reg, x1_next, x2_reg, x2_next;
    logic [YC_W-1:0] cy_reg, cy_next, y2_reg, y2_next;
    logic signed [GEO_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic signed [GEO_W-1:0] dx_reg, dx_next, dy_reg, dy_next, err_reg, err_next;
    logic sx_reg, sx_next, sy_reg, sy_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic rd_ok_reg, rd_ok_next;
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [COLOR_W-1:0] mem_wdata;

    logic signed [GEO_W-1:0] sxa, sya, sxb, syb, urw, urh, uth, saw, sah;
    logic signed [GEO_W-1:0] fx, fy, fw, fh, fx1, fy1, fx2, fy2, fxe, fye;
    logic fill_empty, last_fill, row_end, col_end;
    logic signed [GEO_W-1:0] e2, ldx, ldy;
    logic line_in, line_end, read_in, out_free;
    logic [COUNT_W-1:0] cnt_inc;

    assign sxa = GEO_W'(job_reg.x_a);
    assign sya = GEO_W'(job_reg.y_a);
    assign sxb = GEO_W'(job_reg.x_b);
    assign syb = GEO_W'(job_reg.y_b);
    assign urw = {{(GEO_W-SIZE_W){1'b0}}, job_reg.rect_width};
    assign urh = {{(GEO_W-SIZE_W){1'b0}}, job_reg.rect_height};
    assign uth = {{(GEO_W-SIZE_W){1'b0}}, job_reg.thickness};
    assign saw = {{(GEO_W-CFG_W){1'b0}}, dims.aw};
    assign sah = {{(GEO_W-CFG_W){1'b0}}, dims.ah};

    // pick the current fill and clip it
    always_comb
    begin
        fx = sxa;
        fy = sya;
        fw = urw;
        fh = (job_reg.kind == JOB_OUTLINE) ? uth : urh;
        case (fidx_reg)
            2'd0: ;
            2'd1:
            begin
                fy = sya + urh - uth;
                fh = uth;
            end
            2'd2:
            begin
                fw = uth;
                fh = urh;
            end
            default:
            begin
                fx = sxa + urw - uth;
                fw = uth;
                fh = urh;
            end
        endcase
        fx1 = (fx < 0) ? '0 : fx;
        fy1 = (fy < 0) ? '0 : fy;
        fxe = fx + fw;
        fye = fy + fh;
        fx2 = (fxe > saw) ? saw : fxe;
        fy2 = (fye > sah) ? sah : fye;
        fill_empty = (fw == '0) || (fh == '0) || (fx1 >= fx2) || (fy1 >= fy2);
    end

    assign last_fill = (job_reg.kind != JOB_OUTLINE) || (fidx_reg == 2'd3);
    assign row_end   = (cx_reg + 1'b1 == x2_reg);
    assign col_end   = (cy_reg + 1'b1 == y2_reg);

    assign ldx = (sxb > sxa) ? sxb - sxa : sxa - sxb;
    assign ldy = (syb > sya) ? syb - sya : sya - syb;
    assign e2  = err_reg <<< 1;
    assign line_in  = (lx_reg >= 0) && (ly_reg >= 0) && (lx_reg < saw) && (ly_reg < sah);
    assign line_end = (lx_reg == sxb) && (ly_reg == syb);
    assign read_in  = (sxa >= 0) && (sya >= 0) && (sxa < saw) && (sya < sah);
    assign cnt_inc  = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = B_IDLE;
            B_IDLE:
                if (!q_empty)
                begin
                    case (q_head.kind)
                        JOB_FILL, JOB_OUTLINE: state_next = B_SETUP;
                        JOB_LINE:              state_next = B_LSETUP;
                        JOB_READ:              state_next = B_READ;
                        default:               state_next = B_DONE;
                    endcase
                end
            B_SETUP:
                if (!fill_empty)
                    state_next = B_FILL;
                else if (last_fill)
                    state_next = B_DONE;
            B_FILL:
                if (row_end && col_end)
                    state_next = last_fill ? B_DONE : B_SETUP;
            B_LSETUP: state_next = B_LINE;
            B_LINE:
                if (line_end)
                    state_next = B_DONE;
            B_READ: state_next = B_DONE;
            B_DONE:
                if (out_free)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        job_next       = job_reg;
        fidx_next      = fidx_reg;
        clr_next       = clr_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        err_next       = err_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        cnt_next       = cnt_reg;
        rd_ok_next     = rd_ok_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(cy_reg) * ADDR_W'(MAX_CANVAS_WIDTH) + ADDR_W'(cx_reg);
        mem_wdata      = job_reg.color;
        mem_re         = 1'b0;
        mem_raddr      = ADDR_W'(sya[YC_W-1:0]) * ADDR_W'(MAX_CANVAS_WIDTH)
                         + ADDR_W'(sxa[XC_W-1:0]);
        case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            B_IDLE:
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_head;
                    fidx_next  = 2'd0;
                    cnt_next   = '0;
                    rd_ok_next = 1'b0;
                end
            B_SETUP:
                if (!fill_empty)
                begin
                    x1_next = fx1[XC_W-1:0];
                    cx_next = fx1[XC_W-1:0];
                    cy_next = fy1[YC_W-1:0];
                    x2_next = fx2[XC_W-1:0];
                    y2_next = fy2[YC_W-1:0];
                end
                else if (!last_fill)
                    fidx_next = fidx_reg + 1'b1;
            B_FILL:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_inc;
                if (row_end)
                begin
                    cx_next = x1_reg;
                    if (col_end)
                    begin
                        if (!last_fill)
                            fidx_next = fidx_reg + 1'b1;
                    end
                    else
                        cy_next = cy_reg + 1'b1;
                end
                else
                    cx_next = cx_reg + 1'b1;
            end
            B_LSETUP:
            begin
                lx_next  = sxa;
                ly_next  = sya;
                dx_next  = ldx;
                dy_next  = ldy;
                sx_next  = (sxa < sxb);
                sy_next  = (sya < syb);
                err_next = ldx - ldy;
            end
            B_LINE:
            begin
                mem_we    = line_in;
                mem_waddr = ADDR_W'(ly_reg[YC_W-1:0]) * ADDR_W'(MAX_CANVAS_WIDTH)
                            + ADDR_W'(lx_reg[XC_W-1:0]);
                if (line_in)
                    cnt_next = cnt_inc;
                if (!line_end)
                begin
                    err_next = err_reg - ((e2 > -dy_reg) ? dy_reg : '0)
                               + ((e2 < dx_reg) ? dx_reg : '0);
                    if (e2 > -dy_reg)
                        lx_next = sx_reg ? lx_reg + 1'b1 : lx_reg - 1'b1;
                    if (e2 < dx_reg)
                        ly_next = sy_reg ? ly_reg + 1'b1 : ly_reg - 1'b1;
                end
            end
            B_READ:
            begin
                mem_re     = read_in;
                rd_ok_next = read_in;
            end
            B_DONE:
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.read_color     = rd_ok_reg ? rd_q : '0;
                    out_next.pixels_written = cnt_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        fidx_reg  <= fidx_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        x1_reg    <= x1_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        lx_reg    <= lx_next;
        ly_reg    <= ly_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        err_reg   <= err_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        cnt_reg   <= cnt_next;
        rd_ok_reg <= rd_ok_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            canvas_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_q <= canvas_mem[mem_raddr];
    end

    assign status.clearing = (state_reg == B_CLEAR);
    assign status.idle     = (state_reg == B_IDLE);
    assign out_valid       = out_valid_reg;
    assign out_word        = out_reg;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for canvas_raster_draw_engine_core: directed table, then random phases
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import crde_pkg::*;

    typedef struct {
        cmd_t cmd;
        bit   fixed;
        res_t want;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    cmd_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    res_t out_word;

    canvas_raster_draw_engine_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [31:0] pic [DEPTH];
    int unsigned wreg = 256;
    int unsigned hreg = 256;
    stim_t cmd_fifo[$];
    res_t want_fifo[$];
    bit took = 1'b0;
    bit calm = 1'b0;
    int errors = 0;
    int n_words = 0;
    int n_results = 0;

    function automatic longint act_w();
        return (wreg > MAX_CANVAS_WIDTH) ? MAX_CANVAS_WIDTH : wreg;
    endfunction

    function automatic longint act_h();
        return (hreg > MAX_CANVAS_HEIGHT) ? MAX_CANVAS_HEIGHT : hreg;
    endfunction

    function automatic longint plot(longint x, longint y, logic [31:0] c);
        if (x < 0 || y < 0 || x >= act_w() || y >= act_h())
            return 0;
        pic[y * MAX_CANVAS_WIDTH + x] = c;
        return 1;
    endfunction

    function automatic longint paint_rect(longint x, longint y, longint w, longint h,
                                          logic [31:0] c);
        longint x1, y1, x2, y2;
        if (w <= 0 || h <= 0)
            return 0;
        x1 = (x < 0) ? 0 : x;
        y1 = (y < 0) ? 0 : y;
        x2 = (x + w > act_w()) ? act_w() : x + w;
        y2 = (y + h > act_h()) ? act_h() : y + h;
        if (x1 >= x2 || y1 >= y2)
            return 0;
        for (longint cy = y1; cy < y2; cy++)
            for (longint cx = x1; cx < x2; cx++)
                pic[cy * MAX_CANVAS_WIDTH + cx] = c;
        return (x2 - x1) * (y2 - y1);
    endfunction

    function automatic longint trace_line(longint x, longint y, longint xe, longint ye,
                                          logic [31:0] c);
        longint dx, dy, sx, sy, err, e2, n;
        dx = (xe > x) ? xe - x : x - xe;
        dy = (ye > y) ? ye - y : y - ye;
        sx = (x < xe) ? 1 : -1;
        sy = (y < ye) ? 1 : -1;
        err = dx - dy;
        n = 0;
        forever
        begin
            n += plot(x, y, c);
            if (x == xe && y == ye)
                break;
            e2 = err * 2;
            if (e2 > -dy)
            begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y += sy;
            end
        end
        return n;
    endfunction

    function automatic res_t draw_result(cmd_t c);
        res_t r;
        longint xa, ya, rw, rh, th, n;
        xa = longint'(c.x_a);
        ya = longint'(c.y_a);
        rw = longint'(c.rect_width);
        rh = longint'(c.rect_height);
        th = longint'(c.thickness);
        n = 0;
        r = '0;
        case (c.operation)
            OP_PIXEL:   n = plot(xa, ya, c.color);
            OP_FILL:    n = paint_rect(xa, ya, rw, rh, c.color);
            OP_OUTLINE:
                if (th != 0)
                begin
                    n += paint_rect(xa, ya, rw, th, c.color);
                    n += paint_rect(xa, ya + rh - th, rw, th, c.color);
                    n += paint_rect(xa, ya, th, rh, c.color);
                    n += paint_rect(xa + rw - th, ya, th, rh, c.color);
                end
            OP_LINE:    n = trace_line(xa, ya, longint'(c.x_b), longint'(c.y_b), c.color);
            OP_CLEAR:   n = paint_rect(0, 0, act_w(), act_h(), c.color);
            OP_READ:
                if (xa >= 0 && ya >= 0 && xa < act_w() && ya < act_h())
                    r.read_color = pic[ya * MAX_CANVAS_WIDTH + xa];
            default:    n = 0;
        endcase
        r.pixels_written = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
        return r;
    endfunction

    function automatic cmd_t mk(op_t op, int xa, int ya, int xb, int yb, int rw, int rh,
                                int th, logic [31:0] c);
        cmd_t m;
        m.operation = op;
        m.x_a = COORD_W'(xa);
        m.y_a = COORD_W'(ya);
        m.x_b = COORD_W'(xb);
        m.y_b = COORD_W'(yb);
        m.rect_width = SIZE_W'(rw);
        m.rect_height = SIZE_W'(rh);
        m.thickness = SIZE_W'(th);
        m.color = c;
        return m;
    endfunction

    function automatic int near(int base);
        int d, v;
        d = $urandom_range(40) - 20;
        v = base + d;
        if (v > 32767 || v < -32768)
            v = base - d;
        return v;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t m;
        int lim, reach;
        m = '0;
        m.color = $urandom;
        m.operation = OP_W'($urandom_range(7));
        reach = (act_w() > 64 || act_h() > 64) ? 24 : 44;
        lim = int'((act_w() > act_h()) ? act_w() : act_h());
        if ($urandom_range(99) < 75)
        begin
            m.x_a = COORD_W'($urandom_range(lim + 16) - 8);
            m.y_a = COORD_W'($urandom_range(lim + 16) - 8);
            m.x_b = COORD_W'($urandom_range(lim + 16) - 8);
            m.y_b = COORD_W'($urandom_range(lim + 16) - 8);
            m.rect_width = SIZE_W'($urandom_range(reach));
            m.rect_height = SIZE_W'($urandom_range(reach));
            m.thickness = SIZE_W'($urandom_range(6));
        end
        else
        begin
            m.x_a = COORD_W'($urandom);
            m.y_a = COORD_W'($urandom);
            m.x_b = COORD_W'($urandom);
            m.y_b = COORD_W'($urandom);
            if (reach > 24)
            begin
                m.rect_width = SIZE_W'($urandom);
                m.rect_height = SIZE_W'($urandom);
                m.thickness = SIZE_W'($urandom);
            end
            else
            begin
                m.rect_width = SIZE_W'($urandom_range(reach));
                m.rect_height = SIZE_W'($urandom_range(reach));
                m.thickness = SIZE_W'($urandom_range(reach));
            end
        end
        if (m.operation == OP_LINE)
        begin
            m.x_b = COORD_W'(near(int'(m.x_a)));
            m.y_b = COORD_W'(near(int'(m.y_a)));
        end
        if (m.operation == OP_CLEAR && act_w() * act_h() > 4096)
            m.operation = OP_READ;
        return m;
    endfunction

    task automatic queue_cmd(cmd_t m, bit fixed, res_t want);
        stim_t s;
        s.cmd = m;
        s.fixed = fixed;
        s.want = want;
        cmd_fifo.push_back(s);
    endtask

    task automatic settle();
        wait (cmd_fifo.size() == 0 && !in_valid && want_fifo.size() == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CANVAS_WIDTH)
            wreg = v;
        else
            hreg = v;
    endtask

    always @(posedge clk)
    begin
        took = in_valid && !in_stall;
        if (took)
        begin
            n_words++;
        end
        if (out_valid && !out_stall)
        begin
            n_results++;
            if (want_fifo.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, actual %h/%0d", $time,
                         out_word.read_color, out_word.pixels_written);
            end
            else
            begin
                res_t w;
                w = want_fifo.pop_front();
                if (out_word.read_color !== w.read_color)
                begin
                    errors++;
                    $display("%0t: read_color expected %h actual %h", $time,
                             w.read_color, out_word.read_color);
                end
                if (out_word.pixels_written !== w.pixels_written)
                begin
                    errors++;
                    $display("%0t: pixels_written expected %0d actual %0d", $time,
                             w.pixels_written, out_word.pixels_written);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= !calm && ($urandom_range(99) < 34);
            if (!in_valid || took)
            begin
                if (cmd_fifo.size() != 0 && (calm || $urandom_range(99) >= 34))
                begin
                    stim_t s;
                    res_t p;
                    s = cmd_fifo.pop_front();
                    p = draw_result(s.cmd);
                    want_fifo.push_back(s.fixed ? s.want : p);
                    in_word <= s.cmd;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
                took = 1'b0;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("canvas_raster_draw_engine_core verification failed");
        $finish;
    end

    initial
    begin
        stim_t rows[$];
        int unsigned cw [8] = '{256, 16, 0, 1, 511, 9, 40, 256};
        int unsigned ch [8] = '{256, 12, 9, 1, 3, 0, 33, 256};
        res_t z;
        res_t one;
        res_t full;
        res_t top;
        z = '0;
        one = '0;
        one.pixels_written = COUNT_W'(1);
        full = '0;
        full.pixels_written = COUNT_W'(DEPTH);
        top = '0;
        top.pixels_written = COUNT_MAX;
        for (int i = 0; i < DEPTH; i++)
            pic[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rows = '{
            '{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, z},
            '{mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, one},
            '{mk(OP_READ, 0, 0, -1, -1, 65535, 65535, 65535, 0), 0, z},
            '{mk(OP_PIXEL, -32768, 32767, 0, 0, 0, 0, 0, 32'h1234_5678), 1, z},
            '{mk(OP_READ, 255, 255, 0, 0, 0, 0, 0, 0), 1, z},
            '{mk(OP_READ, 256, 0, 0, 0, 0, 0, 0, 0), 1, z},
            '{mk(OP_FILL, -5, -5, 0, 0, 10, 10, 0, 32'hCAFE_0001), 0, z},
            '{mk(OP_FILL, 3, 3, 0, 0, 0, 9, 0, 32'h1), 1, z},
            '{mk(OP_FILL, 3, 3, 0, 0, 65535, 0, 0, 32'h1), 1, z},
            '{mk(OP_OUTLINE, 3, 3, 0, 0, 9, 9, 0, 32'h2), 1, z},
            '{mk(OP_OUTLINE, 10, 10, 0, 0, 20, 8, 3, 32'h0BAD_F00D), 0, z},
            '{mk(OP_LINE, -32768, -32768, 32767, 32767, 0, 0, 0, 32'h5A5A_0F0F), 0, z},
            '{mk(OP_LINE, 5, 5, 5, 5, 0, 0, 0, 32'h77), 1, one},
            '{mk(OP_LINE, 3, 40, 7, 0, 0, 0, 0, 32'h88), 0, z},
            '{mk(op_t'(3'd6), 1, 1, 1, 1, 1, 1, 1, 32'h99), 1, z},
            '{mk(op_t'(3'd7), 1, 1, 1, 1, 1, 1, 1, 32'h99), 1, z},
            '{mk(OP_READ, 12, 11, 0, 0, 0, 0, 0, 0), 0, z},
            '{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 32'hA5A5_A5A5), 1, full},
            '{mk(OP_OUTLINE, 0, 0, 0, 0, 256, 256, 256, 32'h3C3C_3C3C), 1, top},
            '{mk(OP_READ, 128, 77, 0, 0, 0, 0, 0, 0), 0, z},
            '{mk(OP_FILL, 32767, 32767, 0, 0, 65535, 65535, 0, 32'h4), 1, z},
            '{mk(OP_FILL, -32768, 0, 0, 0, 65535, 1, 0, 32'h5), 0, z},
            '{mk(OP_READ, 200, 0, 0, 0, 0, 0, 0, 0), 0, z}
        };
        foreach (rows[i])
            queue_cmd(rows[i].cmd, rows[i].fixed, rows[i].want);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_CANVAS_WIDTH, cw[ph]);
            write_reg(REG_CANVAS_HEIGHT, ch[ph]);
            calm = (ph == 3);
            for (int i = 0; i < 54; i++)
                queue_cmd(random_cmd(), 1'b0, z);
            settle();
        end
        calm = 1'b0;
        repeat (20) @(negedge clk);

        $display("%0d command words drawn over 8 canvas sizes (zero, one, oversized, full);",
                 n_words);
        $display("%0d results compared, %0d mismatches", n_results, errors);
        if (errors == 0)
            $display("canvas_raster_draw_engine_core verification clean");
        else
            $display("canvas_raster_draw_engine_core verification failed");
        $finish;
    end
endmodule
`default_nettype wire
